// ===== design/crhm_pkg.sv =====
// Package with the shared types and constants of the clock rate health monitor.
`timescale 1ns / 1ps

package crhm_pkg;

    localparam int TIME_W   = 32;
    localparam int IN_CNT_W = 32;
    localparam int TARGET_W = 20;
    localparam int MS_W     = 16;
    localparam int BOUND_W  = 22;
    localparam int REG_IDX_W = 3;
    localparam int REG_DATA_W = 20;

    localparam logic CMD_POLL  = 1'b0;
    localparam logic CMD_RESET = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_CHECK_PERIOD = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_EVENT_TARGET = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_OK_MARGIN    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ERR_MARGIN   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_MIN   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_MAX   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_CPU_GOOD     = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_BUS_GOOD     = 3'd7;

    localparam logic [MS_W-1:0]     RST_CHECK_PERIOD = 16'd1000;
    localparam logic [TARGET_W-1:0] RST_EVENT_TARGET = 20'd1000;
    localparam logic [MS_W-1:0]     RST_OK_MARGIN    = 16'd10;
    localparam logic [MS_W-1:0]     RST_ERR_MARGIN   = 16'd10;
    localparam logic [MS_W-1:0]     RST_WINDOW_MIN   = 16'd900;
    localparam logic [MS_W-1:0]     RST_WINDOW_MAX   = 16'd1100;
    localparam logic                RST_CPU_GOOD     = 1'b0;
    localparam logic                RST_BUS_GOOD     = 1'b1;

    typedef enum logic [1:0] {
        CLS_OK   = 2'd0,
        CLS_WARN = 2'd1,
        CLS_ERR  = 2'd2
    } rate_class_t;

    typedef struct packed {
        logic                command;
        logic [TIME_W-1:0]   now_ms;
        logic [IN_CNT_W-1:0] event_count;
        logic                timer_running;
    } crhm_in_t;

    typedef struct packed {
        logic              healthy;
        logic              window_checked;
        logic [1:0]        rate_class;
        logic              class_changed;
        logic              window_ok;
        logic [TIME_W-1:0] event_delta;
        logic [TIME_W-1:0] elapsed_ms;
    } crhm_out_t;

    typedef struct packed {
        logic [REG_IDX_W-1:0]  index;
        logic [REG_DATA_W-1:0] value;
    } crhm_wr_t;

    typedef struct packed {
        logic [MS_W-1:0]     check_period_ms;
        logic [TARGET_W-1:0] event_target;
        logic [MS_W-1:0]     ok_margin;
        logic [MS_W-1:0]     err_margin;
        logic [MS_W-1:0]     window_min_ms;
        logic [MS_W-1:0]     window_max_ms;
        logic                cpu_clock_good;
        logic                bus_clock_good;
    } crhm_cfg_t;

endpackage

// ===== design/crhm_if.sv =====
// Handshake channel interfaces for poll words, status words and register writes.
`timescale 1ns / 1ps

interface crhm_in_if
    import crhm_pkg::*;
    ;
    logic     valid;
    logic     ready;
    crhm_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface crhm_out_if
    import crhm_pkg::*;
    ;
    logic      valid;
    logic      ready;
    crhm_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface crhm_cfg_if
    import crhm_pkg::*;
    ;
    logic     valid;
    logic     ready;
    crhm_wr_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/crhm_classify.sv =====
// Event-count delta classifier: ok, warning or error against the target rate.
`timescale 1ns / 1ps

module crhm_classify
    import crhm_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic [COUNT_WIDTH-1:0] delta,
    input  crhm_cfg_t              cfg,
    input  logic                   running,
    output rate_class_t            rate_class
);

    localparam int CMPW = (COUNT_WIDTH > BOUND_W) ? COUNT_WIDTH : BOUND_W;

    // True when v lies within margin of center, the lower bound floored at zero.
    function automatic logic near(input logic [CMPW-1:0] v,
                                  input logic [BOUND_W-1:0] center,
                                  input logic [MS_W-1:0] margin);
        logic [BOUND_W-1:0] m;
        logic [BOUND_W-1:0] lo;
        logic [BOUND_W-1:0] hi;
        m  = BOUND_W'(margin);
        lo = (center > m) ? (center - m) : '0;
        hi = center + m;
        return (v >= CMPW'(lo)) && (v <= CMPW'(hi));
    endfunction

    logic [CMPW-1:0]    delta_ext;
    logic [BOUND_W-1:0] center_full;
    logic [BOUND_W-1:0] center_half;
    logic [BOUND_W-1:0] center_double;
    logic               in_ok;
    logic               in_err;

    assign delta_ext     = CMPW'(delta);
    assign center_full   = BOUND_W'(cfg.event_target);
    assign center_half   = BOUND_W'(cfg.event_target >> 1);
    assign center_double = BOUND_W'({cfg.event_target, 1'b0});

    assign in_ok  = near(delta_ext, center_full, cfg.ok_margin);
    assign in_err = near(delta_ext, center_half, cfg.err_margin)
                 || near(delta_ext, center_double, cfg.err_margin);

    always_comb
    begin
        if (!running || in_ok)
        begin
            rate_class = CLS_OK;
        end
        else if (in_err)
        begin
            rate_class = CLS_ERR;
        end
        else
        begin
            rate_class = CLS_WARN;
        end
    end

endmodule

// ===== design/clock_rate_health_monitor_top.sv =====
// Top level of the clock rate health monitor: registers, poll evaluation and status output.
`timescale 1ns / 1ps

// Channel  Role    Word                     Accepted when
// poll     sink    command, time, count     poll.valid and poll.ready
// status   source  health and window result status.valid and status.ready
// cfg      sink    register index and value cfg.valid and cfg.ready
//
// Each poll word is registered in the input register and evaluated there once the
// status register is free; its status word is then registered in the status register.
// One poll word is accepted per cycle while the evaluation stage does not hold; the
// evaluation stage holds only while the status register is full and not taken. Register writes are always accepted.
// After reset the registers hold their defaults and no baseline is stored.

module clock_rate_health_monitor_top
    import crhm_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    crhm_in_if.sink     poll,
    crhm_out_if.source  status,
    crhm_cfg_if.sink    cfg
);

    localparam int CIN = (COUNT_WIDTH < IN_CNT_W) ? COUNT_WIDTH : IN_CNT_W;

    crhm_cfg_t              cfg_reg;
    logic                   in_valid_reg;
    crhm_in_t               in_data_reg;
    logic                   out_valid_reg;
    crhm_out_t              out_data_reg;
    crhm_out_t              out_data_next;
    logic                   baseline_valid_reg;
    logic                   baseline_valid_next;
    logic [TIME_W-1:0]      base_time_reg;
    logic [TIME_W-1:0]      base_time_next;
    logic [COUNT_WIDTH-1:0] base_count_reg;
    logic [COUNT_WIDTH-1:0] base_count_next;
    rate_class_t            prev_class_reg;
    rate_class_t            prev_class_next;

    logic                   advance;
    logic [COUNT_WIDTH-1:0] count_w;
    logic [COUNT_WIDTH-1:0] delta;
    logic [TIME_W-1:0]      elapsed;
    logic                   period_done;
    logic                   win_ok;
    rate_class_t            cls;

    assign advance      = in_valid_reg && (!out_valid_reg || status.ready);
    assign poll.ready   = !in_valid_reg || advance;
    assign cfg.ready    = 1'b1;
    assign status.valid = out_valid_reg;
    assign status.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.check_period_ms <= RST_CHECK_PERIOD;
            cfg_reg.event_target    <= RST_EVENT_TARGET;
            cfg_reg.ok_margin       <= RST_OK_MARGIN;
            cfg_reg.err_margin      <= RST_ERR_MARGIN;
            cfg_reg.window_min_ms   <= RST_WINDOW_MIN;
            cfg_reg.window_max_ms   <= RST_WINDOW_MAX;
            cfg_reg.cpu_clock_good  <= RST_CPU_GOOD;
            cfg_reg.bus_clock_good  <= RST_BUS_GOOD;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                REG_CHECK_PERIOD: cfg_reg.check_period_ms <= cfg.data.value[MS_W-1:0];
                REG_EVENT_TARGET: cfg_reg.event_target    <= cfg.data.value[TARGET_W-1:0];
                REG_OK_MARGIN:    cfg_reg.ok_margin       <= cfg.data.value[MS_W-1:0];
                REG_ERR_MARGIN:   cfg_reg.err_margin      <= cfg.data.value[MS_W-1:0];
                REG_WINDOW_MIN:   cfg_reg.window_min_ms   <= cfg.data.value[MS_W-1:0];
                REG_WINDOW_MAX:   cfg_reg.window_max_ms   <= cfg.data.value[MS_W-1:0];
                REG_CPU_GOOD:     cfg_reg.cpu_clock_good  <= cfg.data.value[0];
                REG_BUS_GOOD:     cfg_reg.bus_clock_good  <= cfg.data.value[0];
                default:          cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (poll.valid && poll.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (status.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll.valid && poll.ready)
        begin
            in_data_reg <= poll.data;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_valid_reg <= 1'b0;
            base_time_reg      <= '0;
            base_count_reg     <= '0;
            prev_class_reg     <= CLS_OK;
        end
        else if (advance)
        begin
            baseline_valid_reg <= baseline_valid_next;
            base_time_reg      <= base_time_next;
            base_count_reg     <= base_count_next;
            prev_class_reg     <= prev_class_next;
        end
    end

    assign count_w     = COUNT_WIDTH'(in_data_reg.event_count[CIN-1:0]);
    assign elapsed     = in_data_reg.now_ms - base_time_reg;
    assign delta       = count_w - base_count_reg;
    assign period_done = elapsed >= TIME_W'(cfg_reg.check_period_ms);
    assign win_ok      = (elapsed >= TIME_W'(cfg_reg.window_min_ms))
                      && (elapsed <= TIME_W'(cfg_reg.window_max_ms));

    crhm_classify #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_classify (
        .delta      (delta),
        .cfg        (cfg_reg),
        .running    (in_data_reg.timer_running),
        .rate_class (cls)
    );

    always_comb
    begin
        out_data_next         = '0;
        out_data_next.healthy = 1'b1;
        baseline_valid_next   = baseline_valid_reg;
        base_time_next        = base_time_reg;
        base_count_next       = base_count_reg;
        prev_class_next       = prev_class_reg;
        if (in_data_reg.command == CMD_RESET)
        begin
            baseline_valid_next = 1'b0;
            base_time_next      = in_data_reg.now_ms;
            base_count_next     = '0;
            prev_class_next     = CLS_OK;
        end
        else if (!baseline_valid_reg)
        begin
            baseline_valid_next = 1'b1;
            base_time_next      = in_data_reg.now_ms;
            base_count_next     = count_w;
        end
        else if (period_done)
        begin
            out_data_next.healthy        = cfg_reg.cpu_clock_good && cfg_reg.bus_clock_good
                                        && win_ok && (cls != CLS_ERR);
            out_data_next.window_checked = 1'b1;
            out_data_next.rate_class     = cls;
            out_data_next.class_changed  = cls != prev_class_reg;
            out_data_next.window_ok      = win_ok;
            out_data_next.event_delta    = TIME_W'(delta);
            out_data_next.elapsed_ms     = elapsed;
            prev_class_next              = cls;
            base_time_next               = in_data_reg.now_ms;
            base_count_next              = count_w;
        end
    end

    // A reset command always leaves the block without a baseline.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_data_reg.command == CMD_RESET) |=> !baseline_valid_reg)
        else $error("baseline still valid after a reset command");

    // The class of a checked window shown on the output is the stored previous class.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.window_checked |-> out_data_reg.rate_class == prev_class_reg)
        else $error("stored class differs from the reported class");

    // An error class never reports healthy.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_data_reg.rate_class == CLS_ERR) |-> !out_data_reg.healthy)
        else $error("healthy reported with an error class");

    // A registered poll word is kept until it moves on to the status register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg))
        else $error("poll word lost while the output stalled");

endmodule

// ===== tb/clock_rate_health_monitor_top_tb.sv =====
// Self-checking testbench for the clock rate health monitor with its own rate predictor.
`timescale 1ns / 1ps

module clock_rate_health_monitor_top_tb;
    import crhm_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 8;
    localparam int PHASE_POLLS = 240;

    logic clk;
    logic rst_n;

    crhm_in_if  poll_ch ();
    crhm_out_if status_ch ();
    crhm_cfg_if cfg_ch ();

    clock_rate_health_monitor_top #(.COUNT_WIDTH(32)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .poll   (poll_ch),
        .status (status_ch),
        .cfg    (cfg_ch)
    );

    crhm_cfg_t   regs;
    logic        have_base;
    logic [31:0] base_time;
    logic [31:0] base_count;
    rate_class_t last_class;

    crhm_out_t   status_due[$];
    logic [31:0] sim_now;
    logic [31:0] sim_count;
    bit          calm;
    int          hold_reqs;
    int          holds_done;
    int          cycle_count;
    int          mismatches;
    int          polls_sent;
    int          windows_seen;
    int          settings_applied;
    int          class_seen[3];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d status words outstanding.",
                     cycle_count, status_due.size());
            $display("FAILURE");
            $finish;
        end
    end

    function automatic bit lies_near(longint unsigned v, longint unsigned centre,
                                     longint unsigned margin);
        longint unsigned lo;
        lo = (centre > margin) ? centre - margin : 0;
        return (v >= lo) && (v <= centre + margin);
    endfunction

    function automatic crhm_out_t predict_status(crhm_in_t w);
        crhm_out_t       r;
        logic [31:0]     span;
        logic [31:0]     diff;
        longint unsigned tgt;
        rate_class_t     cls;
        r = '0;
        r.healthy = 1'b1;
        if (w.command == CMD_RESET)
        begin
            have_base = 1'b0;
            base_time = w.now_ms;
            base_count = '0;
            last_class = CLS_OK;
            return r;
        end
        if (!have_base)
        begin
            have_base = 1'b1;
            base_time = w.now_ms;
            base_count = w.event_count;
            return r;
        end
        span = w.now_ms - base_time;
        if (span < {16'd0, regs.check_period_ms})
            return r;
        diff = w.event_count - base_count;
        tgt = regs.event_target;
        cls = CLS_OK;
        if (w.timer_running && !lies_near(diff, tgt, regs.ok_margin))
        begin
            if (lies_near(diff, tgt / 2, regs.err_margin)
                || lies_near(diff, tgt * 2, regs.err_margin))
                cls = CLS_ERR;
            else
                cls = CLS_WARN;
        end
        r.window_ok = (span >= {16'd0, regs.window_min_ms})
                      && (span <= {16'd0, regs.window_max_ms});
        r.healthy = regs.cpu_clock_good && regs.bus_clock_good && r.window_ok
                    && (cls != CLS_ERR);
        r.window_checked = 1'b1;
        r.rate_class = cls;
        r.class_changed = (cls != last_class);
        r.event_delta = diff;
        r.elapsed_ms = span;
        last_class = cls;
        base_time = w.now_ms;
        base_count = w.event_count;
        windows_seen++;
        class_seen[cls]++;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        crhm_out_t want;
        if (rst_n && status_ch.valid && status_ch.ready)
        begin
            if (status_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected status word, expected none, actual %h",
                         $time, status_ch.data);
            end
            else
            begin
                want = status_due.pop_front();
                check_field("healthy", want.healthy, status_ch.data.healthy);
                check_field("window_checked", want.window_checked,
                            status_ch.data.window_checked);
                check_field("rate_class", want.rate_class, status_ch.data.rate_class);
                check_field("class_changed", want.class_changed,
                            status_ch.data.class_changed);
                check_field("window_ok", want.window_ok, status_ch.data.window_ok);
                check_field("event_delta", want.event_delta, status_ch.data.event_delta);
                check_field("elapsed_ms", want.elapsed_ms, status_ch.data.elapsed_ms);
            end
        end
    end

    // The status side stalls at random, except in calm stretches, and now and then
    // holds off for a long stretch so that the monitor backs up into the poll side.
    initial
    begin
        status_ch.ready = 1'b0;
        wait (rst_n == 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_reqs != holds_done)
            begin
                holds_done++;
                status_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            status_ch.ready <= calm || ($urandom_range(99) >= 7);
        end
    end

    task automatic send_poll(logic cmd, logic [31:0] now, logic [31:0] cnt, logic run);
        crhm_in_t w;
        w.command = cmd;
        w.now_ms = now;
        w.event_count = cnt;
        w.timer_running = run;
        if (!calm && $urandom_range(99) < 7)
        begin
            poll_ch.valid <= 1'b0;
            @(posedge clk);
        end
        poll_ch.valid <= 1'b1;
        poll_ch.data <= w;
        do @(posedge clk); while (!poll_ch.ready);
        status_due.push_back(predict_status(w));
        polls_sent++;
    endtask

    task automatic step_clock(logic [31:0] dt, logic [31:0] dc, logic run);
        sim_now += dt;
        sim_count += dc;
        send_poll(CMD_POLL, sim_now, sim_count, run);
    endtask

    task automatic wait_drained();
        poll_ch.valid <= 1'b0;
        while (status_due.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] index, logic [REG_DATA_W-1:0] value,
                             int width);
        crhm_wr_t              wr;
        logic [REG_DATA_W-1:0] keep;
        logic [REG_DATA_W-1:0] word;
        keep = ({{(REG_DATA_W-1){1'b0}}, 1'b1} << width) - 1'b1;
        word = ($urandom & ~keep) | (value & keep);
        wr.index = index;
        wr.value = word;
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= wr;
        do @(posedge clk); while (!cfg_ch.ready);
        case (index)
            REG_CHECK_PERIOD: regs.check_period_ms = word[MS_W-1:0];
            REG_EVENT_TARGET: regs.event_target = word[TARGET_W-1:0];
            REG_OK_MARGIN:    regs.ok_margin = word[MS_W-1:0];
            REG_ERR_MARGIN:   regs.err_margin = word[MS_W-1:0];
            REG_WINDOW_MIN:   regs.window_min_ms = word[MS_W-1:0];
            REG_WINDOW_MAX:   regs.window_max_ms = word[MS_W-1:0];
            REG_CPU_GOOD:     regs.cpu_clock_good = word[0];
            REG_BUS_GOOD:     regs.bus_clock_good = word[0];
            default:          ;
        endcase
    endtask

    task automatic apply_config(crhm_cfg_t c);
        write_reg(REG_CHECK_PERIOD, c.check_period_ms, MS_W);
        write_reg(REG_EVENT_TARGET, c.event_target, TARGET_W);
        write_reg(REG_OK_MARGIN, c.ok_margin, MS_W);
        write_reg(REG_ERR_MARGIN, c.err_margin, MS_W);
        write_reg(REG_WINDOW_MIN, c.window_min_ms, MS_W);
        write_reg(REG_WINDOW_MAX, c.window_max_ms, MS_W);
        write_reg(REG_CPU_GOOD, c.cpu_clock_good, 1);
        write_reg(REG_BUS_GOOD, c.bus_clock_good, 1);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
        settings_applied++;
    endtask

    function automatic crhm_cfg_t make_config(int period, int target, int okm, int errm,
                                              int wmin, int wmax, bit cpu, bit bus);
        crhm_cfg_t c;
        c.check_period_ms = MS_W'(period);
        c.event_target = TARGET_W'(target);
        c.ok_margin = MS_W'(okm);
        c.err_margin = MS_W'(errm);
        c.window_min_ms = MS_W'(wmin);
        c.window_max_ms = MS_W'(wmax);
        c.cpu_clock_good = cpu;
        c.bus_clock_good = bus;
        return c;
    endfunction

    function automatic int pick_margin();
        case ($urandom_range(3))
            0:       return 0;
            1:       return $urandom_range(0, 65535);
            default: return $urandom_range(0, 100);
        endcase
    endfunction

    function automatic crhm_cfg_t random_config();
        int period;
        int target;
        int spread;
        int wmin;
        int wmax;
        int swap;
        case ($urandom_range(3))
            0:       period = 0;
            1:       period = 65535;
            default: period = $urandom_range(1, 2000);
        endcase
        case ($urandom_range(3))
            0:       target = $urandom_range(1, 100);
            1:       target = $urandom_range(1, 1000000);
            default: target = $urandom_range(100, 5000);
        endcase
        spread = $urandom_range(0, 300);
        wmin = (period > spread) ? period - spread : 0;
        wmax = (period + spread > 65535) ? 65535 : period + spread;
        if ($urandom_range(7) == 0)
        begin
            swap = wmin;
            wmin = wmax;
            wmax = swap;
        end
        return make_config(period, target, pick_margin(), pick_margin(), wmin, wmax,
                           $urandom_range(3) != 0, $urandom_range(3) != 0);
    endfunction

    function automatic logic [31:0] pick_span();
        int period;
        period = regs.check_period_ms;
        case ($urandom_range(9))
            0:       return period;
            1:       return (period == 0) ? 0 : period - 1;
            2:       return regs.window_min_ms;
            3:       return regs.window_min_ms - 1;
            4:       return regs.window_max_ms;
            5:       return regs.window_max_ms + 1;
            6:       return $urandom;
            default: return period + $urandom_range(0, 300);
        endcase
    endfunction

    function automatic logic [31:0] pick_delta();
        longint tgt;
        longint okm;
        longint errm;
        longint d;
        tgt = regs.event_target;
        okm = regs.ok_margin;
        errm = regs.err_margin;
        case ($urandom_range(13))
            0:       d = tgt;
            1:       d = tgt + okm;
            2:       d = tgt - okm;
            3:       d = tgt + okm + 1;
            4:       d = tgt - okm - 1;
            5:       d = tgt / 2 + errm;
            6:       d = tgt / 2 - errm;
            7:       d = tgt / 2 + errm + 1;
            8:       d = tgt * 2 - errm - 1;
            9:       d = tgt * 2 + errm;
            10:      d = tgt * 2 + errm + 1;
            11:      d = $urandom;
            12:      d = 0;
            default: d = $urandom_range(0, 3 * tgt);
        endcase
        return d[31:0];
    endfunction

    task automatic restart_baseline();
        sim_now = $urandom;
        sim_count = $urandom;
        send_poll(CMD_RESET, sim_now, $urandom, 1'($urandom_range(1)));
        sim_now += $urandom_range(0, 50);
        send_poll(CMD_POLL, sim_now, sim_count, 1'b1);
    endtask

    task automatic random_poll();
        int pick;
        pick = $urandom_range(99);
        if (pick < 3)
            restart_baseline();
        else if (pick < 8)
        begin
            sim_now = $urandom;
            sim_count = $urandom;
            send_poll(CMD_POLL, sim_now, sim_count, 1'($urandom_range(1)));
        end
        else
            step_clock(pick_span(), pick_delta(), $urandom_range(9) != 0);
    endtask

    task automatic test_directed();
        crhm_cfg_t c;
        // Default settings leave the cpu clock flag clear, so windows report unhealthy.
        sim_now = 32'hFFFF_FF00;
        sim_count = 32'hFFFF_FFF0;
        send_poll(CMD_POLL, sim_now, sim_count, 1'b1);
        send_poll(CMD_POLL, sim_now + 999, 32'h0, 1'b1);
        step_clock(1000, 1010, 1'b1);
        wait_drained();
        c = regs;
        c.cpu_clock_good = 1'b1;
        apply_config(c);
        step_clock(1100, 990, 1'b1);
        step_clock(1101, 1011, 1'b1);
        step_clock(1000, 500, 1'b1);
        step_clock(1000, 490, 1'b1);
        step_clock(1000, 489, 1'b1);
        step_clock(1000, 2010, 1'b1);
        step_clock(1000, 2011, 1'b1);
        step_clock(1000, 1990, 1'b1);
        step_clock(1000, 0, 1'b0);
        send_poll(CMD_RESET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        sim_now = 32'hFFFF_FFFF;
        sim_count = 32'hFFFF_FFFF;
        send_poll(CMD_POLL, sim_now, sim_count, 1'b0);
        step_clock(1000, 1000, 1'b1);
        wait_drained();
        // Zero period with crossed window bounds and the smallest target.
        apply_config(make_config(0, 1, 0, 0, 65535, 0, 1'b1, 1'b1));
        step_clock(0, 1, 1'b1);
        step_clock(0, 0, 1'b1);
        step_clock(0, 2, 1'b1);
        step_clock(0, 3, 1'b1);
        wait_drained();
        // Longest period, and an error margin wide enough to floor the lower bound.
        apply_config(make_config(65535, 1000, 0, 65535, 0, 65535, 1'b1, 1'b0));
        step_clock(65535, 1, 1'b1);
        step_clock(65534, 7, 1'b1);
        step_clock(65535, 1000, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_settings();
        crhm_cfg_t c;
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
                c = make_config(0, 1, 0, 0, 0, 0, 1'b0, 1'b0);
            else if (p == 1)
                c = make_config(65535, 1000000, 65535, 65535, 65535, 65535, 1'b1, 1'b1);
            else
                c = random_config();
            apply_config(c);
            calm <= (p == 2);
            restart_baseline();
            for (int i = 0; i < PHASE_POLLS; i++)
                random_poll();
            calm <= 1'b0;
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        apply_config(random_config());
        restart_baseline();
        hold_reqs <= hold_reqs + 1;
        for (int i = 0; i < 40; i++)
            random_poll();
        wait_drained();
    endtask

    task automatic test_pause();
        for (int i = 0; i < 20; i++)
            random_poll();
        wait_drained();
        for (int i = 0; i < 20; i++)
            random_poll();
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        poll_ch.valid = 1'b0;
        poll_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        calm = 1'b0;
        hold_reqs = 0;
        holds_done = 0;
        cycle_count = 0;
        mismatches = 0;
        polls_sent = 0;
        windows_seen = 0;
        settings_applied = 0;
        class_seen = '{0, 0, 0};
        regs = make_config(RST_CHECK_PERIOD, RST_EVENT_TARGET, RST_OK_MARGIN, RST_ERR_MARGIN,
                           RST_WINDOW_MIN, RST_WINDOW_MAX, RST_CPU_GOOD, RST_BUS_GOOD);
        have_base = 1'b0;
        base_time = '0;
        base_count = '0;
        last_class = CLS_OK;
        sim_now = '0;
        sim_count = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_settings();
        test_backpressure();
        test_pause();

        wait_drained();
        repeat (5) @(posedge clk);
        $display("Covered %0d polls under %0d register settings, %0d windows evaluated",
                 polls_sent, settings_applied, windows_seen);
        $display("(ok %0d, warning %0d, error %0d), %0d field mismatches.",
                 class_seen[CLS_OK], class_seen[CLS_WARN], class_seen[CLS_ERR], mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/crhm_pkg.sv
design/crhm_if.sv
design/crhm_classify.sv
design/clock_rate_health_monitor_top.sv
tb/clock_rate_health_monitor_top_tb.sv
